/* rtl/core/p4s_pkg.sv */
// Shared types, register codes and saturating arithmetic for the phi^4 site block.
package p4s_pkg;

	localparam int FRAC_BITS_DEF = 24;

	typedef logic signed [63:0] wide_t;
	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_COEF_A     = 2'd0;
	localparam reg_idx_t REG_COEF_B     = 2'd1;
	localparam reg_idx_t REG_COEF_KAPPA = 2'd2;

	localparam logic signed [31:0] COEF_A_RST     = -32'sd52429;
	localparam logic signed [31:0] COEF_B_RST     = 32'sd52429;
	localparam logic signed [31:0] COEF_KAPPA_RST = 32'sd33554;

	localparam wide_t SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] phi;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_z;
		logic signed [31:0] laplacian;
	} site_t;

	typedef struct packed {
		logic signed [31:0] energy_density;
		logic signed [31:0] chem_potential;
		logic signed [31:0] pressure;
		logic signed [31:0] stress_xx;
		logic signed [31:0] stress_xy;
		logic signed [31:0] stress_xz;
		logic signed [31:0] stress_yy;
		logic signed [31:0] stress_yz;
		logic signed [31:0] stress_zz;
	} res_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] kappa;
	} coef_t;

	function automatic wide_t sx64(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	// add, clamped to the symmetric range +-(2^63-1)
	function automatic wide_t sat_add(input wide_t a, input wide_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > SUM_MAX)
			return SAT_MAX;
		else if (s < -SUM_MAX)
			return -SAT_MAX;
		else
			return s[63:0];
	endfunction

	function automatic wide_t sat_sub(input wide_t a, input wide_t b);
		return sat_add(a, -b);
	endfunction

	function automatic logic signed [31:0] clamp32(input wide_t v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	// 0.5*v, rounded half away from zero on the magnitude
	function automatic wide_t scale_half(input wide_t v);
		logic [63:0] mag;
		logic [64:0] t;
		wide_t r;
		mag = v[63] ? -v : v;
		t = {1'b0, mag} + 65'd1;
		r = t[64:1];
		return v[63] ? -r : r;
	endfunction

	// 0.25*v, rounded half away from zero on the magnitude
	function automatic wide_t scale_quarter(input wide_t v);
		logic [63:0] mag;
		logic [64:0] t;
		wide_t r;
		mag = v[63] ? -v : v;
		t = {1'b0, mag} + 65'd2;
		r = {1'b0, t[64:2]};
		return v[63] ? -r : r;
	endfunction

	// 0.75*v, rounded half away from zero on the magnitude
	function automatic wide_t scale_three_q(input wide_t v);
		logic [63:0] mag;
		logic [65:0] t;
		wide_t r;
		mag = v[63] ? -v : v;
		t = {2'b00, mag} + {1'b0, mag, 1'b0} + 66'd2;
		r = t[65:2];
		return v[63] ? -r : r;
	endfunction

endpackage

/* rtl/core/p4s_mulq.sv */
// Four-stage signed fixed-point multiplier with rounding and magnitude saturation.
module p4s_mulq #(
	parameter int FRAC_BITS = p4s_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            en,
	input  p4s_pkg::wide_t  a,
	input  p4s_pkg::wide_t  b,
	output p4s_pkg::wide_t  y
);
	import p4s_pkg::*;

	localparam logic [127:0] RND_BIT = 128'd1 << (FRAC_BITS - 1);

	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  ma_s1, mb_s1;
	logic [63:0]  pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [127:0] prod_s3;
	logic [127:0] rnd;
	logic [127:0] quo;
	logic [63:0]  mag;
	wide_t        y_s4;

	always_comb begin
		rnd = prod_s3 + RND_BIT;
		quo = rnd >> FRAC_BITS;
		mag = (|quo[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, quo[62:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= a[63] ^ b[63];
			ma_s1    <= a[63] ? -a : a;
			mb_s1    <= b[63] ? -b : b;
			neg_s2   <= neg_s1;
			pp_ll_s2 <= ma_s1[31:0] * mb_s1[31:0];
			pp_lh_s2 <= ma_s1[31:0] * mb_s1[63:32];
			pp_hl_s2 <= ma_s1[63:32] * mb_s1[31:0];
			pp_hh_s2 <= ma_s1[63:32] * mb_s1[63:32];
			neg_s3   <= neg_s2;
			prod_s3  <= {64'd0, pp_ll_s2} + {32'd0, pp_lh_s2, 32'd0}
				+ {32'd0, pp_hl_s2, 32'd0} + {pp_hh_s2, 64'd0};
			y_s4     <= neg_s3 ? -mag : mag;
		end
	end

	assign y = y_s4;

endmodule

/* rtl/core/p4s_delay.sv */
// Enabled shift line that aligns a word with a later pipeline stage.
module p4s_delay #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [DEPTH-1:0][WIDTH-1:0] tap_q;

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

/* rtl/core/p4s_cfg.sv */
// Coefficient registers A, B and kappa with their write decode.
module p4s_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  p4s_pkg::reg_idx_t wr_index,
	input  logic [31:0]       wr_data,
	output p4s_pkg::coef_t    coef
);
	import p4s_pkg::*;

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a     <= COEF_A_RST;
			coef_q.b     <= COEF_B_RST;
			coef_q.kappa <= COEF_KAPPA_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_COEF_A:     coef_q.a     <= wr_data;
				REG_COEF_B:     coef_q.b     <= wr_data;
				REG_COEF_KAPPA: coef_q.kappa <= wr_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

/* rtl/core/phi4_site_thermodynamics_top.sv */
// Top level of the phi^4 site thermodynamics pipeline.
//
// One site word (phi, grad_x/y/z, laplacian) enters on the site channel and one
// result word (energy density, chemical potential, pressure and six stress
// entries) leaves on the res channel. A word is taken at a clock edge where its
// valid is high and its stall is low.
// Throughput is one site per cycle while res_stall does not hold the pipeline.
// From acceptance to res_valid a site passes three dependent 4-stage multipliers
// (phi^2, phi^4, B*phi^4), then the saturating add chain and the output clamp.
// Coefficients A, B and kappa are written on the wr_* port with index 0, 1, 2;
// other indexes are dropped. Write them only while the pipeline is empty.
// Reset loads the default coefficients and empties the pipeline.
// When a result waits under res_stall the whole pipeline holds and site_stall
// is raised in the same cycle; nothing is lost or repeated.
module phi4_site_thermodynamics_top #(
	parameter int FRAC_BITS = p4s_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              site_valid,
	output logic              site_stall,
	input  p4s_pkg::site_t    site,
	output logic              res_valid,
	input  logic              res_stall,
	output p4s_pkg::res_t     res,
	input  logic              wr_en,
	input  p4s_pkg::reg_idx_t wr_index,
	input  logic [31:0]       wr_data
);
	import p4s_pkg::*;

	localparam int PIPE_DEPTH = 18;
	localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

	logic                  adv;
	logic [PIPE_DEPTH-1:0] vld_q;
	coef_t                 coef;
	wide_t                 coef_a, coef_b, coef_k;

	wide_t phi_s0, lap_s0;
	wide_t grad_s0 [3];

	wide_t phi2_s4, aphi_s4, klap_s4, kphi_s4, phi_d4, lap_d4;
	logic [5:0][63:0] gab_s4, kgab_s8, kgab_d16;
	wide_t phi3_s8, phi4_s8, aphi2_s8, kphilap_s8;
	wide_t g01_s5, gzz_s5, g2_s6, kg2_s10;
	wide_t bphi3_s12, bphi4_s12;
	wide_t halfa_s9, halfk_s11;
	wide_t aphi_d12, klap_d13, halfa_d13, halfk_d14, kphilap_d14;
	wide_t qb_s13, tqb_s13, mu1_s13;
	wide_t mu_s14, e1_s14, p1_s14;
	wide_t e_s15, p2_s15, mu_s15, halfk_s15;
	wide_t p0_s16, e_s16, mu_s16;
	wide_t e_s17, mu_s17, p0_s17, sxx_s17, sxy_s17, sxz_s17, syy_s17, syz_s17, szz_s17;
	res_t  res_s18;

	// advance everything unless a finished word is held by the receiver
	assign adv        = !res_valid || !res_stall;
	assign site_stall = !adv;
	assign res_valid  = vld_q[PIPE_DEPTH-1];
	assign res        = res_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], site_valid};
		end
	end

	p4s_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coef     (coef)
	);

	assign coef_a     = sx64(coef.a);
	assign coef_b     = sx64(coef.b);
	assign coef_k     = sx64(coef.kappa);
	assign phi_s0     = sx64(site.phi);
	assign lap_s0     = sx64(site.laplacian);
	assign grad_s0[0] = sx64(site.grad_x);
	assign grad_s0[1] = sx64(site.grad_y);
	assign grad_s0[2] = sx64(site.grad_z);

	// first multiply round, straight from the site word
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_phi2 (
		.clk(clk), .en(adv), .a(phi_s0), .b(phi_s0), .y(phi2_s4));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_aphi (
		.clk(clk), .en(adv), .a(coef_a), .b(phi_s0), .y(aphi_s4));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_klap (
		.clk(clk), .en(adv), .a(coef_k), .b(lap_s0), .y(klap_s4));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_kphi (
		.clk(clk), .en(adv), .a(coef_k), .b(phi_s0), .y(kphi_s4));

	generate
		for (genvar k = 0; k < 6; k++) begin : g_pair
			p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_gab (
				.clk(clk), .en(adv), .a(grad_s0[PA[k]]), .b(grad_s0[PB[k]]),
				.y(gab_s4[k]));
			p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_kgab (
				.clk(clk), .en(adv), .a(coef_k), .b(gab_s4[k]), .y(kgab_s8[k]));
		end
	endgenerate

	p4s_delay #(.WIDTH(64), .DEPTH(4)) u_phi_d4 (
		.clk(clk), .en(adv), .d(phi_s0), .q(phi_d4));
	p4s_delay #(.WIDTH(64), .DEPTH(4)) u_lap_d4 (
		.clk(clk), .en(adv), .d(lap_s0), .q(lap_d4));

	// second round
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_phi3 (
		.clk(clk), .en(adv), .a(phi2_s4), .b(phi_d4), .y(phi3_s8));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_phi4 (
		.clk(clk), .en(adv), .a(phi2_s4), .b(phi2_s4), .y(phi4_s8));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_aphi2 (
		.clk(clk), .en(adv), .a(coef_a), .b(phi2_s4), .y(aphi2_s8));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_kphilap (
		.clk(clk), .en(adv), .a(kphi_s4), .b(lap_d4), .y(kphilap_s8));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_kg2 (
		.clk(clk), .en(adv), .a(coef_k), .b(g2_s6), .y(kg2_s10));

	// third round
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_bphi3 (
		.clk(clk), .en(adv), .a(coef_b), .b(phi3_s8), .y(bphi3_s12));
	p4s_mulq #(.FRAC_BITS(FRAC_BITS)) u_bphi4 (
		.clk(clk), .en(adv), .a(coef_b), .b(phi4_s8), .y(bphi4_s12));

	// align side terms with the add chain
	p4s_delay #(.WIDTH(64), .DEPTH(8)) u_aphi_d12 (
		.clk(clk), .en(adv), .d(aphi_s4), .q(aphi_d12));
	p4s_delay #(.WIDTH(64), .DEPTH(9)) u_klap_d13 (
		.clk(clk), .en(adv), .d(klap_s4), .q(klap_d13));
	p4s_delay #(.WIDTH(64), .DEPTH(4)) u_halfa_d13 (
		.clk(clk), .en(adv), .d(halfa_s9), .q(halfa_d13));
	p4s_delay #(.WIDTH(64), .DEPTH(3)) u_halfk_d14 (
		.clk(clk), .en(adv), .d(halfk_s11), .q(halfk_d14));
	p4s_delay #(.WIDTH(64), .DEPTH(6)) u_kphilap_d14 (
		.clk(clk), .en(adv), .d(kphilap_s8), .q(kphilap_d14));
	p4s_delay #(.WIDTH(384), .DEPTH(8)) u_kgab_d16 (
		.clk(clk), .en(adv), .d(kgab_s8), .q(kgab_d16));

	always_ff @(posedge clk) begin
		if (adv) begin
			g01_s5    <= sat_add(gab_s4[0], gab_s4[3]);
			gzz_s5    <= gab_s4[5];
			g2_s6     <= sat_add(g01_s5, gzz_s5);
			halfa_s9  <= scale_half(aphi2_s8);
			halfk_s11 <= scale_half(kg2_s10);

			qb_s13    <= scale_quarter(bphi4_s12);
			tqb_s13   <= scale_three_q(bphi4_s12);
			mu1_s13   <= sat_add(aphi_d12, bphi3_s12);

			mu_s14    <= sat_sub(mu1_s13, klap_d13);
			e1_s14    <= sat_add(halfa_d13, qb_s13);
			p1_s14    <= sat_add(halfa_d13, tqb_s13);

			e_s15     <= sat_add(e1_s14, halfk_d14);
			p2_s15    <= sat_sub(p1_s14, kphilap_d14);
			mu_s15    <= mu_s14;
			halfk_s15 <= halfk_d14;

			p0_s16    <= sat_sub(p2_s15, halfk_s15);
			e_s16     <= e_s15;
			mu_s16    <= mu_s15;

			// diagonal stress takes the unclamped pressure
			sxx_s17   <= sat_add(p0_s16, kgab_d16[0]);
			syy_s17   <= sat_add(p0_s16, kgab_d16[3]);
			szz_s17   <= sat_add(p0_s16, kgab_d16[5]);
			sxy_s17   <= kgab_d16[1];
			sxz_s17   <= kgab_d16[2];
			syz_s17   <= kgab_d16[4];
			p0_s17    <= p0_s16;
			e_s17     <= e_s16;
			mu_s17    <= mu_s16;

			res_s18.energy_density <= clamp32(e_s17);
			res_s18.chem_potential <= clamp32(mu_s17);
			res_s18.pressure       <= clamp32(p0_s17);
			res_s18.stress_xx      <= clamp32(sxx_s17);
			res_s18.stress_xy      <= clamp32(sxy_s17);
			res_s18.stress_xz      <= clamp32(sxz_s17);
			res_s18.stress_yy      <= clamp32(syy_s17);
			res_s18.stress_yz      <= clamp32(syz_s17);
			res_s18.stress_zz      <= clamp32(szz_s17);
		end
	end

endmodule

/* rtl/core/p4s_checker.sv */
// Port-level checks on the phi^4 site pipeline, bound to the top level.
module p4s_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          site_stall,
	input logic          res_valid,
	input logic          res_stall,
	input p4s_pkg::res_t res
);
	import p4s_pkg::*;

	// input is held exactly when a finished word is held
	a_stall_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		site_stall == (res_valid && res_stall))
		else $error("site_stall does not follow the held result");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result word changed or dropped");

	// a new result only shows up after the pipeline has advanced
	a_rise_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!site_stall))
		else $error("result appeared while the pipeline was held");

endmodule

bind phi4_site_thermodynamics_top p4s_checker u_p4s_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.site_stall (site_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);

/* test/phi4_site_thermodynamics_top_tb.sv */
// Self-checking testbench for the phi^4 site thermodynamics block: predictor, driver, monitor.
module phi4_site_thermodynamics_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import p4s_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LAT = 18;
	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD = 300;
	localparam int MAX_SHOWN = 10;
	localparam reg_idx_t REG_UNUSED = 2'd3;

	localparam logic signed [31:0] ONE = 32'sh0100_0000;
	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic signed [63:0] TOP64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] TOP65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] K_HALF = 64'sd1 <<< (FRAC - 1);
	localparam logic signed [63:0] K_QUART = 64'sd1 <<< (FRAC - 2);
	localparam logic signed [63:0] K_3QUART = 64'sd3 <<< (FRAC - 2);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic site_valid = 1'b0;
	logic site_stall;
	site_t site = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic wr_en = 1'b0;
	reg_idx_t wr_index = '0;
	logic [31:0] wr_data = '0;

	site_t pending_sites[$];
	res_t due_res[$];
	coef_t coef_now = '{a: COEF_A_RST, b: COEF_B_RST, kappa: COEF_KAPPA_RST};
	bit idle_on = 1'b1;
	int hold_ticket = 0;
	int fails = 0;
	int shown = 0;
	int n_res = 0;
	int cycles = 0;

	phi4_site_thermodynamics_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.site_valid(site_valid),
		.site_stall(site_stall),
		.site(site),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #5 clk = ~clk;

	// fixed-point product, round half away from zero on the magnitude, then saturate
	function automatic logic signed [63:0] qmul(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic [63:0] mx;
		logic [63:0] my;
		logic [127:0] prod;
		logic [127:0] rnd;
		logic signed [63:0] mag;
		mx = x[63] ? 64'(-x) : 64'(x);
		my = y[63] ? 64'(-y) : 64'(y);
		prod = {64'd0, mx} * {64'd0, my};
		rnd = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
		mag = (rnd > 128'(TOP64)) ? TOP64 : rnd[63:0];
		return (x[63] != y[63]) ? -mag : mag;
	endfunction

	function automatic logic signed [63:0] qadd(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s > TOP65)
			return TOP64;
		if (s < -TOP65)
			return -TOP64;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] qsub(input logic signed [63:0] x,
			input logic signed [63:0] y);
		return qadd(x, -y);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return MAXV;
		if (v < -64'sh0000_0000_8000_0000)
			return MINV;
		return v[31:0];
	endfunction

	function automatic res_t site_thermo(input site_t s, input coef_t c);
		logic signed [63:0] pa, pb, pk, phi, gx, gy, gz, lap;
		logic signed [63:0] phi2, phi3, phi4, gxx, gxy, gxz, gyy, gyz, gzz, g2;
		logic signed [63:0] a_phi2, b_phi4, half_a, half_k, e, mu, p0;
		res_t r;
		pa = $signed(c.a);
		pb = $signed(c.b);
		pk = $signed(c.kappa);
		phi = $signed(s.phi);
		gx = $signed(s.grad_x);
		gy = $signed(s.grad_y);
		gz = $signed(s.grad_z);
		lap = $signed(s.laplacian);
		phi2 = qmul(phi, phi);
		phi3 = qmul(phi2, phi);
		phi4 = qmul(phi2, phi2);
		gxx = qmul(gx, gx);
		gxy = qmul(gx, gy);
		gxz = qmul(gx, gz);
		gyy = qmul(gy, gy);
		gyz = qmul(gy, gz);
		gzz = qmul(gz, gz);
		g2 = qadd(qadd(gxx, gyy), gzz);
		a_phi2 = qmul(pa, phi2);
		b_phi4 = qmul(pb, phi4);
		half_a = qmul(K_HALF, a_phi2);
		half_k = qmul(K_HALF, qmul(pk, g2));
		e = qadd(qadd(half_a, qmul(K_QUART, b_phi4)), half_k);
		mu = qsub(qadd(qmul(pa, phi), qmul(pb, phi3)), qmul(pk, lap));
		p0 = qadd(half_a, qmul(K_3QUART, b_phi4));
		p0 = qsub(p0, qmul(qmul(pk, phi), lap));
		p0 = qsub(p0, half_k);
		r.energy_density = sat32(e);
		r.chem_potential = sat32(mu);
		r.pressure = sat32(p0);
		r.stress_xx = sat32(qadd(p0, qmul(pk, gxx)));
		r.stress_xy = sat32(qmul(pk, gxy));
		r.stress_xz = sat32(qmul(pk, gxz));
		r.stress_yy = sat32(qadd(p0, qmul(pk, gyy)));
		r.stress_yz = sat32(qmul(pk, gyz));
		r.stress_zz = sat32(qadd(p0, qmul(pk, gzz)));
		return r;
	endfunction

	// mostly physical magnitudes, some full range, a few extremes
	function automatic logic signed [31:0] pick_field();
		int unsigned k;
		logic signed [31:0] v;
		k = $urandom_range(0, 99);
		v = $urandom;
		if (k < 45)
			v = v >>> 6;
		else if (k < 75)
			v = v >>> 3;
		else if (k >= 95) begin
			case ($urandom_range(0, 4))
				0: v = MAXV;
				1: v = MINV;
				2: v = '0;
				3: v = ONE;
				default: v = -ONE;
			endcase
		end
		return v;
	endfunction

	task automatic push_site(input logic signed [31:0] p, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z,
			input logic signed [31:0] l);
		pending_sites.push_back('{phi: p, grad_x: x, grad_y: y, grad_z: z, laplacian: l});
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_COEF_A: coef_now.a = val;
			REG_COEF_B: coef_now.b = val;
			REG_COEF_KAPPA: coef_now.kappa = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_sites.size() != 0 || site_valid || due_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] ca, input logic [31:0] cb,
			input logic [31:0] ck, input int n, input bit idle, input bit long_hold);
		write_reg(REG_COEF_A, ca);
		write_reg(REG_COEF_B, cb);
		write_reg(REG_COEF_KAPPA, ck);
		@(posedge clk);
		wr_en <= 1'b0;
		idle_on = idle;
		if (long_hold)
			hold_ticket++;
		repeat (n)
			push_site(pick_field(), pick_field(), pick_field(), pick_field(), pick_field());
		drain();
	endtask

	// driver: hold a word until taken, insert random gaps while idle_on is set
	always @(posedge clk) begin
		int gap_left;
		if (!arst_n) begin
			site_valid <= 1'b0;
			gap_left = 0;
		end else if (!site_valid || !site_stall) begin
			if (site_valid)
				due_res.push_back(site_thermo(site, coef_now));
			if (gap_left > 0) begin
				gap_left--;
				site_valid <= 1'b0;
			end else if (pending_sites.size() == 0) begin
				site_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 7) - 1;
				site_valid <= 1'b0;
			end else begin
				site_valid <= 1'b1;
				site <= pending_sites.pop_front();
			end
		end
	end

	// monitor: check each taken result word, drive stall bursts while idle_on is set, and the long hold
	always @(posedge clk) begin
		int stall_left;
		int hold_seen;
		res_t want;
		logic [31:0] wf;
		logic [31:0] gf;
		string fname[9];
		fname = '{"energy_density", "chem_potential", "pressure", "stress_xx",
			"stress_xy", "stress_xz", "stress_yy", "stress_yz", "stress_zz"};
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
			hold_seen = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_res.size() == 0) begin
					fails++;
					if (shown < MAX_SHOWN) begin
						shown++;
						$display("result word %0d arrived with nothing expected: %h",
							n_res, res);
					end
				end else begin
					want = due_res.pop_front();
					for (int i = 0; i < 9; i++) begin
						wf = want[32 * (8 - i) +: 32];
						gf = res[32 * (8 - i) +: 32];
						if (gf !== wf) begin
							fails++;
							if (shown < MAX_SHOWN) begin
								shown++;
								$display("result word %0d %s: expected %h, got %h",
									n_res, fname[i], wf, gf);
							end
						end
					end
				end
				n_res++;
			end
			if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// a write to the unused index must leave the reset coefficients alone
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		@(posedge clk);
		wr_en <= 1'b0;
		push_site(0, 0, 0, 0, 0);
		push_site(ONE, 0, 0, 0, 0);
		push_site(-ONE, 0, 0, 0, 0);
		push_site(MAXV, 0, 0, 0, 0);
		push_site(MINV, 0, 0, 0, 0);
		push_site(0, MAXV, MINV, MAXV, 0);
		push_site(0, MINV, MINV, MINV, 0);
		push_site(ONE, 0, 0, 0, MAXV);
		push_site(-ONE, 0, 0, 0, MINV);
		push_site(MAXV, MAXV, MAXV, MAXV, MAXV);
		push_site(MINV, MINV, MINV, MINV, MINV);
		// exact half-LSB products: ties round away from zero
		push_site(1 <<< 12, 1 <<< 12, 1 <<< 11, -(1 <<< 11), 1 <<< 11);
		push_site(1, 1, -1, 1, -1);
		push_site(2 * ONE, ONE / 2, -ONE / 4, 3 * ONE / 4, ONE);
		push_site(-2 * ONE, -ONE / 2, ONE / 4, -3 * ONE / 4, -ONE);
		push_site(32'sh0800_0000, ONE, ONE, ONE, 32'sh0800_0000);
		push_site(32'sh00FF_FFFF, 32'sh00FF_FFFF, -32'sh00FF_FFFF, 1, 32'sh00FF_FFFF);
		push_site(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'sh5555_5555);
		push_site(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA);
		push_site(-1, -1, -1, -1, -1);
		drain();

		run_phase(32'($signed($urandom) >>> 7), 32'($signed($urandom) >>> 7),
			32'($signed($urandom) >>> 7), 205, 1'b1, 1'b0);
		run_phase(MAXV, MAXV, MAXV, 205, 1'b1, 1'b0);
		run_phase(MINV, MINV, MINV, 205, 1'b1, 1'b0);
		run_phase(32'd0, 32'd0, 32'd0, 205, 1'b0, 1'b0);
		run_phase($urandom, $urandom, $urandom, 205, 1'b1, 1'b0);
		run_phase(-ONE / 8, ONE / 8, ONE / 64, 205, 1'b1, 1'b1);
		run_phase(MINV, MAXV, MINV, 205, 1'b1, 1'b0);
		run_phase(32'($signed($urandom) >>> 7), 32'($signed($urandom) >>> 7),
			32'($signed($urandom) >>> 7), 205, 1'b0, 1'b0);

		repeat (LAT * 2) @(posedge clk);
		if (fails == 0 && due_res.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
